// File: rtl/core/pcc_pkg.sv
// Shared constants, codes and control structs of the phase current conditioner.
// No dependencies; every other file imports this package.
package pcc_pkg;

	localparam int MEDIAN_SAMPLES = 8;
	localparam int PHASES         = 3;

	localparam int MV_W    = 12;
	localparam int ALPHA_W = 17;
	localparam int CNT_W   = 16;
	localparam int SUM_W   = 28;
	localparam int FILT_W  = 28;
	localparam int CUR_W   = 19;
	localparam int PH_W    = 2;
	localparam int CIDX_W  = 4;
	localparam int CDAT_W  = 17;
	localparam int FILL_W  = $clog2(MEDIAN_SAMPLES + 1);

	localparam logic [ALPHA_W-1:0] Q16_ONE   = 17'd65536;
	localparam logic [MV_W-1:0]    MV_RESET  = 12'd1650;
	localparam int                 CUR_LIMIT = 250000;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_ALPHA_A    = 4'd0;
	localparam logic [CIDX_W-1:0] REG_ALPHA_REST = 4'd1;
	localparam logic [CIDX_W-1:0] REG_NOMINAL    = 4'd2;
	localparam logic [CIDX_W-1:0] REG_MANUAL_EN  = 4'd3;
	localparam logic [CIDX_W-1:0] REG_MANUAL_A   = 4'd4;
	localparam logic [CIDX_W-1:0] REG_MANUAL_B   = 4'd5;
	localparam logic [CIDX_W-1:0] REG_MANUAL_C   = 4'd6;
	localparam logic [CIDX_W-1:0] REG_CAL_COUNT  = 4'd7;

	typedef struct packed {
		logic            push;
		logic            start;
		logic [MV_W-1:0] sample;
	} med_ctrl_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_ctrl_t;

endpackage

// File: rtl/core/pcc_if.sv
// Handshake channels of the phase current conditioner: sample items, result items
// and register writes. Depends on pcc_pkg for field widths.
interface pcc_in_if import pcc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            action;
	logic [PH_W-1:0] phase;
	logic [MV_W-1:0] sample_mv;
	modport source (output valid, action, phase, sample_mv, input ready);
	modport sink   (input valid, action, phase, sample_mv, output ready);
endinterface

interface pcc_out_if import pcc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [PH_W-1:0]         out_phase;
	logic signed [CUR_W-1:0] current_ma;
	logic                    cal_done;
	logic                    is_calibrated;
	modport source (output valid, out_phase, current_ma, cal_done, is_calibrated, input ready);
	modport sink   (input valid, out_phase, current_ma, cal_done, is_calibrated, output ready);
endinterface

interface pcc_cfg_if import pcc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [CDAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/phase_current_conditioner_unit.sv
// Phase current conditioner: one millivolt sample item in, at most one current item
// out, one item at a time. A measure item of phase B or C runs the filter update
// after calibration, its three products one after another on a shared 17x17
// multiplier. Every MEDIAN_SAMPLES-th phase A item first runs the median sort:
// MEDIAN_SAMPLES-1 passes of MEDIAN_SAMPLES+1 compare steps; the other phase A items
// are only pushed into the median line. The item that completes calibration runs
// three serial divisions. Calibration items that complete nothing and ignored items
// give no result. A result held back by the receiver holds the block in its emit
// state. Write registers only while no item is in flight.
// Depends on pcc_pkg, pcc_if, pcc_median and pcc_div.
module phase_current_conditioner_unit import pcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pcc_in_if.sink     sample,
	pcc_out_if.source  result,
	pcc_cfg_if.sink    cfg
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SORT = 4'd1;
	localparam logic [3:0] S_EMA0 = 4'd2;
	localparam logic [3:0] S_EMA1 = 4'd3;
	localparam logic [3:0] S_EMA2 = 4'd4;
	localparam logic [3:0] S_EMA3 = 4'd5;
	localparam logic [3:0] S_CUR  = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_DIVW = 4'd8;
	localparam logic [3:0] S_EMIT = 4'd9;

	// registers
	logic [ALPHA_W-1:0] alpha_a_q, alpha_rest_q;
	logic [MV_W-1:0]    nominal_q;
	logic               manual_en_q;
	logic [MV_W-1:0]    manual_q [PHASES];
	logic [CNT_W-1:0]   cal_count_q;

	// per-phase state
	logic [FILT_W-1:0]      filt_q  [PHASES];
	logic [MV_W-1:0]        eff_q   [PHASES];
	logic signed [MV_W:0]   bench_q [PHASES];
	logic [SUM_W-1:0]       sum_q   [PHASES];
	logic [CNT_W-1:0]       seen_q  [PHASES];
	logic                   calib_q;
	logic [FILL_W-1:0]      fill_q;

	logic [3:0]         state_q;
	logic [PH_W-1:0]    ph_q;
	logic [MV_W-1:0]    mv_q;
	logic [PH_W-1:0]    qidx_q;
	logic [ALPHA_W-1:0] mul_a, mul_b;
	logic [2*ALPHA_W-1:0] prod_q;
	logic [FILT_W:0]    acc_q;
	logic signed [CUR_W-1:0] res_cur_q;
	logic               res_done_q;

	logic               out_valid_q;
	logic [PH_W-1:0]    out_phase_q;
	logic signed [CUR_W-1:0] out_cur_q;
	logic               out_done_q;
	logic               out_cal_q;

	med_ctrl_t          med_ctrl;
	logic               med_done;
	logic [MV_W-1:0]    med_val;
	div_ctrl_t          div_ctrl;
	logic               div_done;
	logic [MV_W-1:0]    div_quo;

	logic               in_fire;
	logic               cfg_fire;
	logic [PH_W-1:0]    rd_idx;
	logic [CNT_W-1:0]   need;
	logic               room;
	logic               all_seen;
	logic [ALPHA_W-1:0] alpha_sel, a_eff, b_eff;
	logic [FILT_W-1:0]  f_cur;
	logic [FILT_W-1:0]  f_new;
	logic signed [MV_W+1:0]  d_mv;
	logic signed [21:0] cur_full;
	logic signed [21:0] cur_pre, cur_cal;
	logic signed [CUR_W-1:0] cur_sat;
	logic [17:0]        fhi50;
	logic [21:0]        flo50;

	assign in_fire   = sample.valid && sample.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;
	assign sample.ready = (state_q == S_IDLE);

	// one read port on the sums: incoming phase when idle, else the division index
	assign rd_idx = (state_q == S_IDLE) ? sample.phase : qidx_q;
	assign need   = (cal_count_q == '0) ? CNT_W'(1) : cal_count_q;
	assign room   = seen_q[rd_idx] < need;

	always_comb begin
		all_seen = 1'b1;
		for (int q = 0; q < PHASES; q++) begin
			if (PH_W'(q) == sample.phase) begin
				if (!(room || seen_q[q] >= need) || (room && (seen_q[q] + 1'b1) < need))
					all_seen = 1'b0;
			end else if (seen_q[q] < need) begin
				all_seen = 1'b0;
			end
		end
	end

	// filter weights, clamped to one
	assign alpha_sel = (ph_q == '0) ? alpha_a_q : alpha_rest_q;
	assign a_eff     = (alpha_sel > Q16_ONE) ? Q16_ONE : alpha_sel;
	assign b_eff     = Q16_ONE - a_eff;
	assign f_cur     = filt_q[ph_q];

	always_comb begin
		case (state_q)
			S_EMA0: begin
				mul_a = a_eff;
				mul_b = ALPHA_W'(mv_q);
			end
			S_EMA1: begin
				mul_a = b_eff;
				mul_b = ALPHA_W'(f_cur[FILT_W-1:16]);
			end
			default: begin
				mul_a = b_eff;
				mul_b = ALPHA_W'(f_cur[15:0]);
			end
		endcase
	end

	always_ff @(posedge clk)
		prod_q <= mul_a * mul_b;

	// current: once calibrated from the updated filter state, rounded half up; before from sample minus nominal
	assign f_new   = acc_q[FILT_W-1:0];
	assign d_mv    = (MV_W+2)'(bench_q[ph_q]) - $signed({2'b0, eff_q[ph_q]});
	assign fhi50   = 18'(f_new[FILT_W-1:16]) * 18'd50;
	assign flo50   = 22'(f_new[15:0]) * 22'd50 + 22'd32768;
	assign cur_cal = 22'(d_mv) * 22'sd50 + $signed({4'b0, fhi50})
		+ $signed({16'b0, flo50[21:16]});
	assign cur_pre = ($signed({10'b0, mv_q}) - $signed({10'b0, nominal_q})) * 22'sd50;
	assign cur_full = calib_q ? cur_cal : cur_pre;

	always_comb begin
		if (cur_full > 22'sd250000)
			cur_sat = CUR_W'(CUR_LIMIT);
		else if (cur_full < -22'sd250000)
			cur_sat = CUR_W'(-CUR_LIMIT);
		else
			cur_sat = cur_full[CUR_W-1:0];
	end

	always_comb begin
		med_ctrl.push   = 1'b0;
		med_ctrl.start  = 1'b0;
		med_ctrl.sample = sample.sample_mv;
		if (MEDIAN_SAMPLES >= 3 && in_fire && !sample.action && sample.phase == '0) begin
			med_ctrl.push  = 1'b1;
			med_ctrl.start = (fill_q == FILL_W'(MEDIAN_SAMPLES - 1));
		end
	end

	assign div_ctrl.start    = (state_q == S_DIV);
	assign div_ctrl.dividend = sum_q[rd_idx];
	assign div_ctrl.divisor  = seen_q[rd_idx];

	pcc_median u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (med_ctrl),
		.done   (med_done),
		.median (med_val)
	);

	pcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ph_q <= sample.phase;
			mv_q <= sample.sample_mv;
		end else if (state_q == S_SORT && med_done) begin
			mv_q <= med_val;
		end
		case (state_q)
			S_EMA1: acc_q <= (FILT_W+1)'(prod_q);
			S_EMA2: acc_q <= acc_q + (FILT_W+1)'(prod_q);
			S_EMA3: acc_q <= acc_q + (FILT_W+1)'((35'(prod_q) + 35'd32768) >> 16);
			default: acc_q <= acc_q;
		endcase
		if (state_q == S_CUR) begin
			res_cur_q  <= cur_sat;
			res_done_q <= 1'b0;
		end else if (state_q == S_DIVW && div_done && qidx_q == PH_W'(PHASES - 1)) begin
			res_cur_q  <= '0;
			res_done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_a_q    <= 17'd3277;
			alpha_rest_q <= 17'd16384;
			nominal_q    <= MV_RESET;
			manual_en_q  <= 1'b0;
			cal_count_q  <= 16'd64;
			for (int q = 0; q < PHASES; q++) begin
				manual_q[q] <= MV_RESET;
				filt_q[q]   <= {MV_RESET, 16'd0};
				eff_q[q]    <= MV_RESET;
				bench_q[q]  <= '0;
				sum_q[q]    <= '0;
				seen_q[q]   <= '0;
			end
			calib_q     <= 1'b0;
			fill_q      <= '0;
			state_q     <= S_IDLE;
			qidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				case (cfg.index)
					REG_ALPHA_A:    alpha_a_q    <= cfg.data;
					REG_ALPHA_REST: alpha_rest_q <= cfg.data;
					REG_NOMINAL:    nominal_q    <= cfg.data[MV_W-1:0];
					REG_MANUAL_EN:  manual_en_q  <= cfg.data[0];
					REG_MANUAL_A:   manual_q[0]  <= cfg.data[MV_W-1:0];
					REG_MANUAL_B:   manual_q[1]  <= cfg.data[MV_W-1:0];
					REG_MANUAL_C:   manual_q[2]  <= cfg.data[MV_W-1:0];
					REG_CAL_COUNT:  cal_count_q  <= cfg.data[CNT_W-1:0];
					default: ;
				endcase
			end

			// the emit state refills the output register itself
			if (result.ready && state_q != S_EMIT)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_fire && sample.phase < PH_W'(PHASES)) begin
						if (sample.action) begin
							if (room) begin
								sum_q[rd_idx]  <= sum_q[rd_idx] + SUM_W'(sample.sample_mv);
								seen_q[rd_idx] <= seen_q[rd_idx] + 1'b1;
							end
							if (all_seen) begin
								qidx_q  <= '0;
								state_q <= S_DIV;
							end
						end else if (MEDIAN_SAMPLES >= 3 && sample.phase == '0) begin
							if (fill_q == FILL_W'(MEDIAN_SAMPLES - 1)) begin
								fill_q  <= '0;
								state_q <= S_SORT;
							end else begin
								fill_q <= fill_q + 1'b1;
							end
						end else begin
							state_q <= S_EMA0;
						end
					end
				end
				S_SORT: begin
					if (med_done)
						state_q <= S_EMA0;
				end
				S_EMA0: state_q <= calib_q ? S_EMA1 : S_CUR;
				S_EMA1: state_q <= S_EMA2;
				S_EMA2: state_q <= S_EMA3;
				S_EMA3: state_q <= S_CUR;
				S_CUR: begin
					if (calib_q)
						filt_q[ph_q] <= f_new;
					state_q <= S_EMIT;
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_done) begin
						filt_q[qidx_q] <= {div_quo, 16'd0};
						if (manual_en_q) begin
							eff_q[qidx_q]   <= manual_q[qidx_q];
							bench_q[qidx_q] <= $signed({1'b0, manual_q[qidx_q]})
								- $signed({1'b0, div_quo});
						end else begin
							eff_q[qidx_q]   <= div_quo;
							bench_q[qidx_q] <= '0;
						end
						if (qidx_q == PH_W'(PHASES - 1)) begin
							for (int q = 0; q < PHASES; q++) begin
								sum_q[q]  <= '0;
								seen_q[q] <= '0;
							end
							calib_q <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							qidx_q  <= qidx_q + 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_EMIT: begin
					// hold until the output register is free
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && (!out_valid_q || result.ready)) begin
			out_phase_q <= ph_q;
			out_cur_q   <= res_cur_q;
			out_done_q  <= res_done_q;
			out_cal_q   <= calib_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.out_phase     = out_phase_q;
	assign result.current_ma    = out_cur_q;
	assign result.cal_done      = out_done_q;
	assign result.is_calibrated = out_cal_q;

endmodule

// File: rtl/core/pcc_median.sv
// Phase A median unit: a shift line of samples sorted in place by one shared
// compare stage that streams the line past a carry register. Depends on pcc_pkg.
module pcc_median import pcc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  med_ctrl_t       ctrl,
	output logic            done,
	output logic [MV_W-1:0] median
);

	localparam int STEP_W = $clog2(MEDIAN_SAMPLES + 1);
	localparam int PASS_W = $clog2(MEDIAN_SAMPLES);
	localparam int MID    = MEDIAN_SAMPLES / 2;

	logic [MV_W-1:0]   line_q [MEDIAN_SAMPLES];
	logic [MV_W-1:0]   carry_q;
	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [PASS_W-1:0] pass_q;
	logic              gt;
	logic [MV_W-1:0]   lo, hi, tail;
	logic              last_step;

	assign gt   = carry_q > line_q[0];
	assign lo   = gt ? line_q[0] : carry_q;
	assign hi   = gt ? carry_q : line_q[0];
	assign last_step = (step_q == STEP_W'(MEDIAN_SAMPLES));

	always_comb begin
		if (step_q == '0)
			tail = line_q[0];
		else if (last_step)
			tail = carry_q;
		else
			tail = lo;
	end

	// stream one pass: take the head, keep the larger in the carry, append the smaller
	always_ff @(posedge clk) begin
		if (ctrl.push && !busy_q) begin
			for (int k = 0; k < MEDIAN_SAMPLES - 1; k++)
				line_q[k] <= line_q[k+1];
			line_q[MEDIAN_SAMPLES-1] <= ctrl.sample;
		end else if (busy_q) begin
			for (int k = 0; k < MEDIAN_SAMPLES - 1; k++)
				line_q[k] <= line_q[k+1];
			line_q[MEDIAN_SAMPLES-1] <= tail;
			carry_q <= (step_q == '0) ? line_q[0] : hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			pass_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (ctrl.start) begin
					busy_q <= 1'b1;
					step_q <= '0;
					pass_q <= '0;
				end
			end else if (last_step) begin
				step_q <= '0;
				if (pass_q == PASS_W'(MEDIAN_SAMPLES - 2)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					pass_q <= pass_q + 1'b1;
				end
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_comb begin
		if (MEDIAN_SAMPLES % 2 == 0)
			median = MV_W'(({1'b0, line_q[MID-1]} + {1'b0, line_q[MID]}) >> 1);
		else
			median = line_q[MID];
	end

	assign done = done_q;

endmodule

// File: rtl/core/pcc_div.sv
// Restoring divider, one quotient bit a cycle, for the calibration averages.
// Depends on pcc_pkg.
module pcc_div import pcc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  div_ctrl_t       ctrl,
	output logic            done,
	output logic [MV_W-1:0] quotient
);

	localparam int BIT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] quo_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [BIT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W+1:0] diff;

	assign trial = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (ctrl.start && !busy_q) begin
			quo_q <= ctrl.dividend;
			rem_q <= '0;
			dvs_q <= ctrl.divisor;
		end else if (busy_q) begin
			if (!diff[CNT_W+1]) begin
				rem_q <= diff[CNT_W:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (ctrl.start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (cnt_q == BIT_W'(SUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// averages never exceed the largest sample
	assign quotient = quo_q[MV_W-1:0];
	assign done     = done_q;

endmodule
